// ----- rtl/ffb_pkg.sv -----
`default_nettype none
package ffb_pkg;

  localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
  localparam logic [15:0] CRC_PRESET  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam int          QUEUE_DEPTH = 4;

  // One classified payload byte, as handed from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       open;      // send the opening flag first
    logic       last;      // send FCS and closing flag after the data
    logic [7:0] fcs_lo;
    logic [7:0] fcs_hi;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_DATA,
    PH_FCS_LO,
    PH_FCS_HI,
    PH_CLOSE
  } phase_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // MSB-first CRC-16 update over one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ffb_if.sv -----
`default_nettype none
interface ffb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       frame_end;

  modport source (output valid, output payload_byte, output frame_end, input ready);
  modport sink   (input valid, input payload_byte, input frame_end, output ready);
endinterface

interface ffb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_last;
  logic       frame_last;

  modport source (output valid, output line_byte, output run_last, output frame_last,
                  input ready);
  modport sink   (input valid, input line_byte, input run_last, input frame_last,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/ffb_front.sv -----
`default_nettype none
module ffb_front
  import ffb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic [7:0] in_payload_byte,
  input  wire logic    in_frame_end,
  input  wire q_stat_t q_stat,
  output logic         push,
  output cmd_t         push_cmd
);

  logic [15:0] crc_r, crc_nxt;
  logic        open_r, open_nxt;
  logic [15:0] crc_base, crc_new, fcs;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    crc_base = open_r ? crc_r : CRC_PRESET;
    crc_new  = crc_byte(crc_base, rev8(in_payload_byte));
    fcs      = crc_new ^ CRC_PRESET;

    push_cmd.data   = in_payload_byte;
    push_cmd.open   = !open_r;
    push_cmd.last   = in_frame_end;
    push_cmd.fcs_lo = rev8(fcs[15:8]);
    push_cmd.fcs_hi = rev8(fcs[7:0]);

    crc_nxt  = crc_r;
    open_nxt = open_r;
    if (push) begin
      if (in_frame_end) begin
        crc_nxt  = CRC_PRESET;
        open_nxt = 1'b0;
      end else begin
        crc_nxt  = crc_new;
        open_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_PRESET;
      open_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      open_r <= open_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ffb_fifo.sv -----
`default_nettype none
module ffb_fifo
  import ffb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output q_stat_t   q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- rtl/ffb_back.sv -----
`default_nettype none
module ffb_back
  import ffb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cmd_t    head,
  input  wire q_stat_t q_stat,
  output logic         pop,
  ffb_out_if.source    out_ch
);

  phase_t     phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       run_last_r, run_last_nxt;
  logic       frame_last_r, frame_last_nxt;
  logic       load, emit;

  assign load = !out_valid_r || out_ch.ready;
  assign emit = load && !q_stat.empty;

  always_comb begin
    phase_nxt      = phase_r;
    out_valid_nxt  = out_valid_r;
    byte_nxt       = byte_r;
    run_last_nxt   = run_last_r;
    frame_last_nxt = frame_last_r;
    pop            = 1'b0;

    if (load) begin
      out_valid_nxt = emit;
    end

    if (emit) begin
      frame_last_nxt = 1'b0;
      case (phase_r)
        PH_HEAD: begin
          if (head.open) begin
            byte_nxt  = FLAG_BYTE;
            phase_nxt = PH_DATA;
          end else begin
            byte_nxt = head.data;
            if (head.last) begin
              phase_nxt = PH_FCS_LO;
            end else begin
              pop = 1'b1;
            end
          end
        end
        PH_DATA: begin
          byte_nxt = head.data;
          if (head.last) begin
            phase_nxt = PH_FCS_LO;
          end else begin
            pop       = 1'b1;
            phase_nxt = PH_HEAD;
          end
        end
        PH_FCS_LO: begin
          byte_nxt  = head.fcs_lo;
          phase_nxt = PH_FCS_HI;
        end
        PH_FCS_HI: begin
          byte_nxt  = head.fcs_hi;
          phase_nxt = PH_CLOSE;
        end
        PH_CLOSE: begin
          byte_nxt       = FLAG_BYTE;
          frame_last_nxt = 1'b1;
          pop            = 1'b1;
          phase_nxt      = PH_HEAD;
        end
        default: begin
          phase_nxt = PH_HEAD;
        end
      endcase
      run_last_nxt = pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    run_last_r   <= run_last_nxt;
    frame_last_r <= frame_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_byte  = byte_r;
  assign out_ch.run_last   = run_last_r;
  assign out_ch.frame_last = frame_last_r;

  // Mid-entry phases always have their entry still at the queue head.
  a_entry_held: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_HEAD |-> !q_stat.empty)
    else $error("entry lost mid sequence");

  // The closing flag ends its transaction group.
  a_close_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && frame_last_r |-> run_last_r && byte_r == FLAG_BYTE)
    else $error("closing flag without run end");

  // Popping only happens while sending a byte.
  a_pop_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> emit)
    else $error("queue pop without output transaction");

endmodule
`default_nettype wire

// ----- rtl/flagged_frame_builder_crc16_top.sv -----
`default_nettype none
// Channel   Role    Fields                                   Accepted when
// in_ch     sink    payload_byte[7:0], frame_end             valid && ready
// out_ch    source  line_byte[7:0], run_last, frame_last     valid && ready
//
// Each input transaction yields 1 to 5 output transactions, one per cycle
// unless out_ch stalls: plain payload bytes sustain one transaction per
// cycle on both sides. A frame's first byte adds an opening flag; its last
// byte adds FCS low, FCS high and the closing flag, sent by the back
// sequencer's output register. The front computes the CRC combinationally.
// Bytes are registered in the queue, then in the back output register.
// Reset (synchronous, rst_n low) empties the queue, restores CRC to 0xFFFF
// and closes any open frame. in_ch.ready drops only while the queue is full.
module flagged_frame_builder_crc16_top
  import ffb_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH  // entries between front and back
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ffb_in_if.sink    in_ch,
  ffb_out_if.source out_ch
);

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    push;
  logic    pop;

  // Front: accepts bytes, runs the CRC, tags flag/FCS needs per byte.
  ffb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_payload_byte (in_ch.payload_byte),
    .in_frame_end    (in_ch.frame_end),
    .q_stat          (q_stat),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  // Short queue decoupling the two sides.
  ffb_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Back: expands each entry into its line bytes.
  ffb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
